[hw/rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator - shared package
// Payload structs, status and register codes, and controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;

  localparam int NB_W       = 11;  // num_blocks register
  localparam int BS_W       = 16;  // block_size register
  localparam int CFG_DATA_W = 16;
  localparam int BYTES_W    = 16;
  localparam int RIDX_W     = 10;  // release_index / block_index fields
  localparam int OFFS_W     = 26;
  localparam int FCNT_W     = 11;

  localparam logic [NB_W-1:0] NUM_BLOCKS_RST = 11'd1024;
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 16'd64;

  typedef enum logic [0:0] {
    CFG_NUM_BLOCKS = 1'b0,
    CFG_BLOCK_SIZE = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_ALL_FREE  = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [BYTES_W-1:0]  request_bytes;
    logic [RIDX_W-1:0]   release_index;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [RIDX_W-1:0]   block_index;
    logic [OFFS_W-1:0]   byte_offset;
    logic [FCNT_W-1:0]   free_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;  // capture incoming item
    logic exec;      // check and commit the held item
    logic pop;       // finish an acquire with the link read back
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acq_go;    // held item is an acquire that will succeed
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/fbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator - controller
// Tracks the held item and the result register, sequences execute and pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  fbpa_pkg::sts_t sts,
  output fbpa_pkg::cmd_t cmd
);
  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_POP = 2'b10
  } state_t;

  state_t state, state_next;
  logic   req_full, req_full_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = !req_full;
  assign rsp_valid = out_valid;

  always_comb begin
    cmd.load_req = req_valid && !req_full;
    cmd.exec     = (state == S_RUN) && req_full && out_free;
    cmd.pop      = (state == S_POP);
  end

  always_comb begin
    state_next     = state;
    req_full_next  = req_full;
    out_valid_next = out_valid && !rsp_ready;
    if (cmd.load_req) begin
      req_full_next = 1'b1;
    end else if (cmd.exec) begin
      req_full_next = 1'b0;
    end
    unique case (state)
      S_RUN: begin
        if (cmd.exec) begin
          if (sts.acq_go) begin
            state_next = S_POP;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_POP: begin
        // result register was freed at the execute edge
        state_next     = S_RUN;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      req_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_full  <= req_full_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fbpa_dp.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator - datapath
// Configuration, free list head and counters, link memory, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_dp #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  fbpa_pkg::cfg_idx_t              cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  fbpa_pkg::req_t                  req,
  input  fbpa_pkg::cmd_t                  cmd,
  output fbpa_pkg::sts_t                  sts,
  output fbpa_pkg::rsp_t                  rsp
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (CNT_W > NB_W) ? CNT_W : NB_W;
  localparam int PW    = IDX_W + BS_W;

  function automatic logic [CNT_W-1:0] eff_count(input logic [NB_W-1:0] v);
    if (CW'(v) > CW'(MAX_BLOCKS)) begin
      return CNT_W'(MAX_BLOCKS);
    end
    return CNT_W'(v);
  endfunction

  logic [NB_W-1:0]  num_blocks;
  logic [BS_W-1:0]  block_size;
  logic [IDX_W-1:0] head;
  logic             head_valid;
  logic [CNT_W-1:0] free_blocks;
  logic [CNT_W-1:0] init_blocks;

  req_t             req_q;
  logic [IDX_W-1:0] granted;
  logic [CNT_W-1:0] link_rd;
  logic             bypass;
  rsp_t             rsp_q;
  rsp_t             rsp_next;

  logic [CNT_W-1:0] link_mem [MAX_BLOCKS];

  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] cfg_n;
  logic             is_acq, too_large, empty, rel_bad, all_free;
  logic             acq_go, rel_go, init_pending;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [CNT_W-1:0] link_wdata;
  logic [CNT_W-1:0] nxt;
  logic [PW-1:0]    prod;

  assign n     = eff_count(num_blocks);
  assign cfg_n = eff_count(cfg_wdata[NB_W-1:0]);

  assign is_acq       = (req_q.req_type == REQ_ACQUIRE);
  assign too_large    = (req_q.request_bytes > block_size);
  assign empty        = (free_blocks == '0) || !head_valid || (CNT_W'(head) >= n);
  assign rel_bad      = (CW'(req_q.release_index) >= CW'(n));
  assign all_free     = (free_blocks >= n);
  assign acq_go       = is_acq && !too_large && !empty;
  assign rel_go       = !is_acq && !rel_bad && !all_free;
  assign init_pending = (init_blocks < n);

  assign sts.acq_go = acq_go;

  // acquire links the next untouched block; release pushes onto the head
  assign link_we    = cmd.exec && ((acq_go && init_pending) || rel_go);
  assign link_waddr = acq_go ? IDX_W'(init_blocks) : IDX_W'(req_q.release_index);
  assign link_wdata = acq_go ? (init_blocks + CNT_W'(1))
                             : (head_valid ? CNT_W'(head) : n);

  // head was the block just linked: its link is head + 1, not yet in memory
  assign nxt  = bypass ? (CNT_W'(granted) + CNT_W'(1)) : link_rd;
  assign prod = PW'(granted) * PW'(block_size);

  always_comb begin
    rsp_next             = '0;
    rsp_next.status      = ST_OK;
    rsp_next.free_count  = FCNT_W'(free_blocks);
    if (cmd.pop) begin
      rsp_next.block_index = RIDX_W'(granted);
      rsp_next.byte_offset = OFFS_W'(prod);
    end else if (is_acq) begin
      if (too_large) begin
        rsp_next.status = ST_TOO_LARGE;
      end else if (empty) begin
        rsp_next.status = ST_EMPTY;
      end
    end else begin
      if (rel_bad) begin
        rsp_next.status = ST_RANGE;
      end else if (all_free) begin
        rsp_next.status = ST_ALL_FREE;
      end else begin
        rsp_next.free_count = FCNT_W'(free_blocks + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks  <= NUM_BLOCKS_RST;
      block_size  <= BLOCK_SIZE_RST;
      head        <= '0;
      head_valid  <= 1'b1;
      free_blocks <= eff_count(NUM_BLOCKS_RST);
      init_blocks <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_BLOCKS: begin
          num_blocks  <= cfg_wdata[NB_W-1:0];
          head        <= '0;
          head_valid  <= (cfg_n != '0);
          free_blocks <= cfg_n;
          init_blocks <= '0;
        end
        CFG_BLOCK_SIZE: begin
          block_size <= cfg_wdata[BS_W-1:0];
        end
      endcase
    end else if (cmd.exec) begin
      if (acq_go) begin
        free_blocks <= free_blocks - CNT_W'(1);
        if (init_pending) begin
          init_blocks <= init_blocks + CNT_W'(1);
        end
      end else if (rel_go) begin
        head        <= IDX_W'(req_q.release_index);
        head_valid  <= 1'b1;
        free_blocks <= free_blocks + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      // a link at or beyond the count is the end marker
      if ((free_blocks != '0) && (nxt < n)) begin
        head <= IDX_W'(nxt);
      end else begin
        head_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      granted <= head;
      link_rd <= link_mem[head];
      bypass  <= init_pending && (CNT_W'(head) == init_blocks);
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if ((cmd.exec && !acq_go) || cmd.pop) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp = rsp_q;

endmodule

`default_nettype wire

[hw/rtl/fixed_block_pool_allocator.sv]
// Timing: release and failed requests are captured in the request register,
//   then written to the result register; a granted acquire adds a pop step first.
// Flow: one item is held at a time; it executes once the result register
//   is free and no pop is pending, which frees the request register.
// Reset: synchronous; restores num_blocks 1024 and block_size 64 with an
//   empty list build; the link memory is not cleared, it is filled lazily.
// ----------------------------------------------------------------------------
// Fixed block pool allocator - top level
// Free list of equal-size blocks held in a link memory, built on demand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  fbpa_pkg::cfg_idx_t              cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  fbpa_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output fbpa_pkg::rsp_t                  rsp
);
  import fbpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[hw/rtl/fbpa_chk.sv]
// ----------------------------------------------------------------------------
// Fixed block pool allocator - port checker
// Concurrent checks on the top level ports, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_chk #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fbpa_pkg::rsp_t rsp
);
  import fbpa_pkg::*;

  // one item in hand at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item accepted while another still held");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // a new result only ever follows a held item; a granted acquire
  // first spends a pop step on the link read
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready) || !$past(req_ready, 2))
    else $error("result appeared with no item held");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.block_index == '0) &&
                                           (rsp.byte_offset == '0))
    else $error("failed request carries a block");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.free_count <= MAX_BLOCKS))
    else $error("free count beyond pool size");

endmodule

bind fixed_block_pool_allocator fbpa_chk #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator - testbench
// Walks a table of directed requests and register writes, then random
// phases with new pool settings. Each result is checked against its table
// entry or a pool model kept here; both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;
  import fbpa_pkg::*;

  localparam int MAX_BLK = DEF_MAX_BLOCKS;

  typedef struct {
    bit        is_cfg;
    cfg_idx_t  idx;
    logic [CFG_DATA_W-1:0] val;
    req_t      r;
    bit        typed;
    rsp_t      want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_NUM_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;

  // pool model state
  logic [NB_W-1:0]   pool_nb;
  logic [BS_W-1:0]   pool_bs;
  logic [NB_W-1:0]   link_mem [MAX_BLK];
  logic [RIDX_W-1:0] head;
  bit                head_ok;
  logic [FCNT_W-1:0] free_cnt;
  logic [NB_W-1:0]   built_cnt;

  rsp_t              alloc_results_q[$];
  logic [RIDX_W-1:0] held_q[$];
  int unsigned       tx_lvl = 1;
  int unsigned       rx_lvl = 1;
  int unsigned       acq_pct = 50;
  int unsigned       rx_hold = 0;
  int unsigned       fail_cnt = 0;
  int unsigned       shown = 0;
  int unsigned       rsp_seen = 0;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(MAX_BLK)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void pool_restart();
    free_cnt  = (pool_nb > MAX_BLK) ? FCNT_W'(MAX_BLK) : pool_nb;
    head      = '0;
    head_ok   = (free_cnt != 0);
    built_cnt = '0;
    held_q.delete();
  endfunction

  function automatic void pool_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    if (idx == CFG_NUM_BLOCKS) begin
      pool_nb = v[NB_W-1:0];
      pool_restart();
    end else begin
      pool_bs = v[BS_W-1:0];
    end
  endfunction

  function automatic rsp_t pool_apply(req_t r);
    rsp_t o;
    int unsigned n;
    int unsigned nxt;
    n = (pool_nb > MAX_BLK) ? MAX_BLK : pool_nb;
    o = '0;
    o.status = ST_OK;
    if (r.req_type == REQ_ACQUIRE) begin
      if (r.request_bytes > pool_bs) begin
        o.status = ST_TOO_LARGE;
      end else if (free_cnt == 0 || !head_ok || head >= n) begin
        o.status = ST_EMPTY;
      end else begin
        // lazy build: link the next untouched block to its successor
        if (built_cnt < n) begin
          link_mem[built_cnt] = built_cnt + 1'b1;
          built_cnt = built_cnt + 1'b1;
        end
        o.block_index = head;
        o.byte_offset = OFFS_W'(32'(head) * 32'(pool_bs));
        free_cnt = free_cnt - 1'b1;
        if (free_cnt != 0) begin
          nxt = link_mem[head];
          if (nxt < n) head = nxt[RIDX_W-1:0];
          else head_ok = 1'b0;
        end else begin
          head_ok = 1'b0;
        end
      end
    end else begin
      if (r.release_index >= n) begin
        o.status = ST_RANGE;
      end else if (free_cnt >= n) begin
        o.status = ST_ALL_FREE;
      end else begin
        link_mem[r.release_index] = head_ok ? NB_W'(head) : NB_W'(n);
        head     = r.release_index;
        head_ok  = 1'b1;
        free_cnt = free_cnt + 1'b1;
      end
    end
    o.free_count = free_cnt;
    return o;
  endfunction

  // no gap at level 0; else often no gap, some short ones, a few long ones
  function automatic int unsigned idle_len(int unsigned lvl);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (lvl == 0) return 0;
    if (p < ((lvl == 1) ? 70 : 35)) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int unsigned p;
    int unsigned pos;
    p = $urandom_range(0, 99);
    r.request_bytes = BYTES_W'($urandom_range(0, 65535));
    r.release_index = RIDX_W'($urandom_range(0, MAX_BLK - 1));
    if (p < 12) begin
      // noise: raw fields, double releases, out of range, oversize
      r.req_type = p[0] ? REQ_RELEASE : REQ_ACQUIRE;
    end else if ($urandom_range(0, 99) < acq_pct || held_q.size() == 0) begin
      r.req_type = REQ_ACQUIRE;
      r.request_bytes = BYTES_W'($urandom_range(0, pool_bs));
    end else begin
      r.req_type = REQ_RELEASE;
      pos = $urandom_range(0, held_q.size() - 1);
      r.release_index = held_q[pos];
      held_q.delete(pos);
    end
    return r;
  endfunction

  function automatic step_row_t mk_req(req_type_t t, logic [BYTES_W-1:0] b,
                                       logic [RIDX_W-1:0] ri);
    step_row_t s;
    s.is_cfg = 1'b0;
    s.idx = CFG_NUM_BLOCKS;
    s.val = '0;
    s.r.req_type = t;
    s.r.request_bytes = b;
    s.r.release_index = ri;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_row_t mk_chk(req_type_t t, logic [BYTES_W-1:0] b,
                                       logic [RIDX_W-1:0] ri, status_t st,
                                       logic [RIDX_W-1:0] bi, logic [OFFS_W-1:0] off,
                                       logic [FCNT_W-1:0] fc);
    step_row_t s;
    s = mk_req(t, b, ri);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.block_index = bi;
    s.want.byte_offset = off;
    s.want.free_count = fc;
    return s;
  endfunction

  function automatic step_row_t mk_cfg(cfg_idx_t i, logic [CFG_DATA_W-1:0] v);
    step_row_t s;
    s = mk_req(REQ_ACQUIRE, '0, '0);
    s.is_cfg = 1'b1;
    s.idx = i;
    s.val = v;
    return s;
  endfunction

  task automatic drain();
    req_valid <= 1'b0;
    while (alloc_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_write(idx, v);
    @(posedge clk);
  endtask

  task automatic issue(req_t r, bit typed, rsp_t want);
    int unsigned gap;
    rsp_t got;
    gap = idle_len(tx_lvl);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    got = pool_apply(r);
    alloc_results_q.push_back(typed ? want : got);
    if (r.req_type == REQ_ACQUIRE && got.status == ST_OK) held_q.push_back(got.block_index);
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rsp_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      rsp_ready <= 1'b1;
      rx_hold <= idle_len(rx_lvl);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_seen <= rsp_seen + 1;
      if (alloc_results_q.size() == 0) begin
        fail_cnt <= fail_cnt + 1;
        if (shown < 10) $display("result %0d: no request outstanding", rsp_seen);
        shown <= shown + 1;
      end else begin
        e = alloc_results_q.pop_front();
        if (rsp.status !== e.status || rsp.block_index !== e.block_index ||
            rsp.byte_offset !== e.byte_offset || rsp.free_count !== e.free_count) begin
          fail_cnt <= fail_cnt + 1;
          if (shown < 10)
            $display("result %0d: status %0d/%0d index %0d/%0d offset %0d/%0d free %0d/%0d",
                     rsp_seen, e.status, rsp.status, e.block_index, rsp.block_index,
                     e.byte_offset, rsp.byte_offset, e.free_count, rsp.free_count);
          shown <= shown + 1;
        end
      end
    end
  end

  initial begin
    step_row_t rows[$];
    logic [CFG_DATA_W-1:0] nb_val;
    logic [CFG_DATA_W-1:0] bs_val;
    pool_nb = NUM_BLOCKS_RST;
    pool_bs = BLOCK_SIZE_RST;
    pool_restart();

    // defaults after reset: 1024 blocks of 64 bytes
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd0, 10'd0, ST_OK, 10'd0, 26'd0, 11'd1023));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd64, 10'd0, ST_OK, 10'd1, 26'd64, 11'd1022));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd65, 10'd0, ST_TOO_LARGE, 10'd0, 26'd0, 11'd1022));
    // top block never handed out goes back on the list anyway
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd1023, ST_OK, 10'd0, 26'd0, 11'd1023));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd0, ST_OK, 10'd0, 26'd0, 11'd1024));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd1, ST_ALL_FREE, 10'd0, 26'd0, 11'd1024));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd1, 10'd0));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd1, 10'd0));
    // zero block size
    rows.push_back(mk_cfg(CFG_BLOCK_SIZE, 16'd0));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd0, 10'd0));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd1, 10'd0));
    rows.push_back(mk_cfg(CFG_BLOCK_SIZE, 16'hFFFF));
    rows.push_back(mk_cfg(CFG_NUM_BLOCKS, 16'd1024));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'hFFFF, 10'd0, ST_OK, 10'd0, 26'd0, 11'd1023));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'hFFFF, 10'd0, ST_OK, 10'd1, 26'd65535, 11'd1022));
    // empty pool; oversize wins over empty
    rows.push_back(mk_cfg(CFG_NUM_BLOCKS, 16'd0));
    rows.push_back(mk_cfg(CFG_BLOCK_SIZE, 16'd1));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd0, 10'd0, ST_EMPTY, 10'd0, 26'd0, 11'd0));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd2, 10'd0, ST_TOO_LARGE, 10'd0, 26'd0, 11'd0));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd0, ST_RANGE, 10'd0, 26'd0, 11'd0));
    // count saturates at the pool maximum
    rows.push_back(mk_cfg(CFG_NUM_BLOCKS, 16'hFFFF));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd1023, ST_ALL_FREE, 10'd0, 26'd0, 11'd1024));
    rows.push_back(mk_cfg(CFG_NUM_BLOCKS, 16'd1));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd1, ST_RANGE, 10'd0, 26'd0, 11'd1));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd0, 10'd0, ST_OK, 10'd0, 26'd0, 11'd0));
    rows.push_back(mk_chk(REQ_ACQUIRE, 16'd0, 10'd0, ST_EMPTY, 10'd0, 26'd0, 11'd0));
    rows.push_back(mk_chk(REQ_RELEASE, 16'd0, 10'd0, ST_OK, 10'd0, 26'd0, 11'd1));
    // release of the untouched head, then the lazy link hits the end marker
    // with one block still counted free
    rows.push_back(mk_cfg(CFG_NUM_BLOCKS, 16'd3));
    rows.push_back(mk_cfg(CFG_BLOCK_SIZE, 16'd16));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd16, 10'd0));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd0, 10'd0));
    rows.push_back(mk_req(REQ_RELEASE, 16'd0, 10'd2));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd0, 10'd0));
    rows.push_back(mk_req(REQ_ACQUIRE, 16'd0, 10'd0));
    rows.push_back(mk_req(REQ_RELEASE, 16'd0, 10'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        issue(rows[i].r, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case ($urandom_range(0, 7))
        0:       nb_val = 16'd1024;
        1:       nb_val = 16'd1;
        2:       nb_val = CFG_DATA_W'($urandom_range(1025, 65535));
        3:       nb_val = CFG_DATA_W'($urandom_range(100, 1024));
        default: nb_val = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       bs_val = 16'd0;
        1:       bs_val = 16'hFFFF;
        2:       bs_val = 16'd1;
        default: bs_val = CFG_DATA_W'($urandom_range(1, 4096));
      endcase
      cfg_write(CFG_NUM_BLOCKS, nb_val);
      cfg_write(CFG_BLOCK_SIZE, bs_val);
      tx_lvl  = ph % 3;
      rx_lvl  = (ph / 3) % 3;
      acq_pct = $urandom_range(35, 75);
      for (int k = 0; k < 150; k++) begin
        if (k == 75) drain();
        issue(rand_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && alloc_results_q.size() == 0) begin
      $display("fixed_block_pool_allocator: match");
    end else begin
      $display("fixed_block_pool_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fixed_block_pool_allocator: mismatch");
    $finish;
  end

endmodule
